[design/nca_pkg.sv]
// shared types and codes for the nearest centroid anomaly classifier
`default_nettype none

package nca_pkg;

    localparam int COORD_BITS  = 16;
    localparam int ENTRY_BITS  = 7;
    localparam int DIM_BITS    = 3;
    localparam int THR_BITS    = 16;
    localparam int REGIME_BITS = 2;
    localparam int KIND_BITS   = 2;
    localparam int COUNT_BITS  = 8;
    localparam int INDEX_BITS  = 7;
    localparam int DIST_BITS   = 35;
    localparam int DEC_BITS    = 2;

    // input item kinds
    localparam logic [KIND_BITS-1:0] KIND_CENTROID = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_THRESH   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_QUERY    = 2'd2;

    // queued operations
    localparam logic [1:0] OP_CENTROID = 2'd0;
    localparam logic [1:0] OP_THRESH   = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    // regime labels
    localparam logic [REGIME_BITS-1:0] REGIME_PROVISION = 2'd0;
    localparam logic [REGIME_BITS-1:0] REGIME_TAKER     = 2'd1;

    // decisions
    localparam logic [DEC_BITS-1:0] DEC_CANCEL    = 2'd0;
    localparam logic [DEC_BITS-1:0] DEC_TAKER     = 2'd1;
    localparam logic [DEC_BITS-1:0] DEC_PROVISION = 2'd2;
    localparam logic [DEC_BITS-1:0] DEC_HOLD      = 2'd3;

    typedef struct packed {
        logic [1:0]                    op;
        logic                          store;
        logic                          search;
        logic [ENTRY_BITS-1:0]         entry;
        logic [DIM_BITS-1:0]           dim;
        logic signed [COORD_BITS-1:0]  coord;
        logic [THR_BITS-1:0]           threshold;
        logic [REGIME_BITS-1:0]        regime;
    } nca_req_t;

    typedef struct packed {
        logic [1:0] fill;
    } nca_front_stat_t;

    typedef struct packed {
        logic active;
    } nca_back_stat_t;

endpackage

`default_nettype wire

[design/nca_ram.sv]
// generic simple dual port ram with registered read
`default_nettype none

module nca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/nca_front.sv]
// front end: accepts items, sorts them into operations and queues them
`default_nettype none

module nca_front
    import nca_pkg::*;
#(
    parameter int MAX_ENTRIES = 128,
    parameter int DIMS        = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [KIND_BITS-1:0]          kind,
    input  wire logic [ENTRY_BITS-1:0]         entry,
    input  wire logic [DIM_BITS-1:0]           dim,
    input  wire logic signed [COORD_BITS-1:0]  coord_value,
    input  wire logic [THR_BITS-1:0]           threshold,
    input  wire logic [REGIME_BITS-1:0]        regime,
    input  wire logic                          last,
    input  wire logic                          pop,
    output logic                               busy,
    output logic                               req_valid,
    output nca_req_t                           req,
    output nca_front_stat_t                    stat
);

    nca_req_t   item;
    logic       ent_ok;
    logic       dim_ok;
    logic       push;
    logic       do_pop;

    nca_req_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign ent_ok = 32'(entry) < 32'(MAX_ENTRIES);
    assign dim_ok = 32'(dim) < 32'(DIMS);

    always_comb
    begin
        item.entry     = entry;
        item.dim       = dim;
        item.coord     = coord_value;
        item.threshold = threshold;
        item.regime    = regime;
        item.search    = 1'b0;
        case (kind)
            KIND_CENTROID:
            begin
                item.op    = OP_CENTROID;
                item.store = ent_ok && dim_ok;
            end
            KIND_THRESH:
            begin
                item.op    = OP_THRESH;
                item.store = ent_ok;
            end
            KIND_QUERY:
            begin
                item.op     = OP_QUERY;
                item.store  = dim_ok;
                item.search = last;
            end
            default:
            begin
                item.op    = OP_NONE;
                item.store = 1'b0;
            end
        endcase
    end

    assign busy      = (fill_reg == 2'd2);
    // requests that change nothing are dropped here
    assign push      = start && !busy && (item.store || item.search);
    assign req_valid = (fill_reg != 2'd0);
    assign do_pop    = pop && req_valid;
    assign req       = slot_reg[rd_ptr_reg];
    assign stat.fill = fill_reg;

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

[design/nca_back.sv]
// back end: table stores, query buffer and the distance search engine
`default_nettype none

module nca_back
    import nca_pkg::*;
#(
    parameter int MAX_ENTRIES = 128,
    parameter int DIMS        = 5
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [COUNT_BITS-1:0]  centroid_count,
    input  wire logic                   req_valid,
    input  wire nca_req_t               req,
    output logic                        pop,
    output logic                        done,
    output logic [INDEX_BITS-1:0]       best_index,
    output logic [DIST_BITS-1:0]        distance_sq,
    output logic                        anomaly,
    output logic [DEC_BITS-1:0]         decision,
    output nca_back_stat_t              stat
);

    localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int QW    = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int DEPTH = MAX_ENTRIES * DIMS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SQW   = 2 * COORD_BITS;
    localparam int DW    = SQW + $clog2(DIMS);
    localparam int TW    = THR_BITS + REGIME_BITS;
    localparam logic [DW-1:0] COORD_MAX = DW'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic [DW-1:0] MAX_DIST  = DW'(DIMS) * COORD_MAX * COORD_MAX;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_TSQ   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [IW-1:0] k_reg, k_next;
    logic [QW-1:0] d_reg, d_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] n_eff;

    // stage 1: ram read in flight
    logic                         s1_valid_reg;
    logic                         s1_first_reg, s1_last_reg;
    logic [IW-1:0]                s1_k_reg;
    logic signed [COORD_BITS-1:0] s1_q_reg;
    // stage 2: squared difference
    logic                         s2_valid_reg;
    logic                         s2_first_reg, s2_last_reg;
    logic [IW-1:0]                s2_k_reg;
    logic [SQW-1:0]               s2_sq_reg;
    // stage 3: accumulate and compare
    logic [DW-1:0]                acc_reg;
    logic [DW-1:0]                best_sq_reg;
    logic [IW-1:0]                best_reg;
    logic [SQW-1:0]               tsq_reg;
    logic [REGIME_BITS-1:0]       regime_reg;

    logic                         done_reg, done_next;
    logic [INDEX_BITS-1:0]        idx_reg, idx_next;
    logic [DIST_BITS-1:0]         dist_reg, dist_next;
    logic                         anom_reg, anom_next;
    logic [DEC_BITS-1:0]          dec_reg, dec_next;

    logic signed [COORD_BITS-1:0] qbuf_reg [DIMS];

    logic                         last_d, last_k;
    logic                         cent_we, thr_we, qry_we;
    logic [AW-1:0]                cent_waddr;
    logic [COORD_BITS-1:0]        cent_rdata;
    logic [TW-1:0]                thr_rdata;
    logic signed [COORD_BITS:0]   diff;
    logic [COORD_BITS-1:0]        mag;
    logic [SQW-1:0]               sq;
    logic [DW-1:0]                sum;
    logic                         is_anom;

    always_comb
    begin
        if (32'(centroid_count) > 32'(MAX_ENTRIES))
        begin
            n_eff = CW'(MAX_ENTRIES);
        end
        else
        begin
            n_eff = CW'(centroid_count);
        end
    end

    assign pop        = (state_reg == S_IDLE) && req_valid;
    assign cent_we    = pop && req.store && (req.op == OP_CENTROID);
    assign thr_we     = pop && req.store && (req.op == OP_THRESH);
    assign qry_we     = pop && req.store && (req.op == OP_QUERY);
    assign cent_waddr = AW'(AW'(IW'(req.entry)) * AW'(DIMS) + AW'(req.dim));

    nca_ram #(
        .WIDTH (COORD_BITS),
        .DEPTH (DEPTH)
    ) u_cent_ram (
        .clk   (clk),
        .we    (cent_we),
        .waddr (cent_waddr),
        .wdata (req.coord),
        .raddr (addr_reg),
        .rdata (cent_rdata)
    );

    // threshold and regime share one word; read address follows the best entry
    nca_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_ENTRIES)
    ) u_thr_ram (
        .clk   (clk),
        .we    (thr_we),
        .waddr (IW'(req.entry)),
        .wdata ({req.regime, req.threshold}),
        .raddr (best_reg),
        .rdata (thr_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (qry_we)
        begin
            qbuf_reg[QW'(req.dim)] <= req.coord;
        end
    end

    assign last_d = (32'(d_reg) == 32'(DIMS - 1));
    assign last_k = (32'(k_reg) + 32'd1 == 32'(n_reg));

    // squared difference of the coordinate pair leaving the ram
    assign diff = $signed({cent_rdata[COORD_BITS-1], cent_rdata})
                - $signed({s1_q_reg[COORD_BITS-1], s1_q_reg});
    assign mag  = diff[COORD_BITS] ? COORD_BITS'(-diff) : COORD_BITS'(diff);
    assign sq   = SQW'(mag) * SQW'(mag);

    assign sum     = (s2_first_reg ? '0 : acc_reg) + DW'(s2_sq_reg);
    assign is_anom = best_sq_reg > DW'(tsq_reg);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        d_next     = d_reg;
        addr_next  = addr_reg;
        n_next     = n_reg;
        done_next  = 1'b0;
        idx_next   = idx_reg;
        dist_next  = dist_reg;
        anom_next  = anom_reg;
        dec_next   = dec_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pop && req.search)
                begin
                    if (n_eff == '0)
                    begin
                        done_next = 1'b1;
                        idx_next  = '0;
                        dist_next = DIST_BITS'(MAX_DIST);
                        anom_next = 1'b1;
                        dec_next  = DEC_CANCEL;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                        k_next     = '0;
                        d_next     = '0;
                        addr_next  = '0;
                        n_next     = n_eff;
                    end
                end
            end
            S_SCAN:
            begin
                addr_next = addr_reg + AW'(1);
                if (last_d)
                begin
                    d_next = '0;
                    k_next = k_reg + IW'(1);
                    if (last_k)
                    begin
                        state_next = S_DRAIN;
                    end
                end
                else
                begin
                    d_next = d_reg + QW'(1);
                end
            end
            S_DRAIN:
            begin
                // threshold read of the winner is issued once the pipe is empty
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = S_TSQ;
                end
            end
            S_TSQ:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                idx_next   = INDEX_BITS'(best_reg);
                dist_next  = DIST_BITS'(best_sq_reg);
                anom_next  = is_anom;
                if (is_anom)
                begin
                    dec_next = DEC_CANCEL;
                end
                else if (regime_reg == REGIME_TAKER)
                begin
                    dec_next = DEC_TAKER;
                end
                else if (regime_reg == REGIME_PROVISION)
                begin
                    dec_next = DEC_PROVISION;
                end
                else
                begin
                    dec_next = DEC_HOLD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= (state_reg == S_SCAN);
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        d_reg        <= d_next;
        addr_reg     <= addr_next;
        n_reg        <= n_next;
        idx_reg      <= idx_next;
        dist_reg     <= dist_next;
        anom_reg     <= anom_next;
        dec_reg      <= dec_next;
        s1_first_reg <= (d_reg == '0);
        s1_last_reg  <= last_d;
        s1_k_reg     <= k_reg;
        s1_q_reg     <= qbuf_reg[d_reg];
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_k_reg     <= s1_k_reg;
        s2_sq_reg    <= sq;
        if (s2_valid_reg)
        begin
            acc_reg <= sum;
            if (s2_last_reg && (s2_k_reg == '0 || sum < best_sq_reg))
            begin
                best_sq_reg <= sum;
                best_reg    <= s2_k_reg;
            end
        end
        if (state_reg == S_TSQ)
        begin
            tsq_reg    <= SQW'(thr_rdata[THR_BITS-1:0]) * SQW'(thr_rdata[THR_BITS-1:0]);
            regime_reg <= thr_rdata[TW-1:THR_BITS];
        end
    end

    assign done        = done_reg;
    assign best_index  = idx_reg;
    assign distance_sq = dist_reg;
    assign anomaly     = anom_reg;
    assign decision    = dec_reg;
    assign stat.active = (state_reg != S_IDLE);

endmodule

`default_nettype wire

[design/nearest_centroid_anomaly_classifier.sv]
// Nearest centroid classifier with anomaly flag. Requests are taken whenever
// busy is low and go into a two-deep queue; busy rises only when that queue
// is full. The back end drains the queue one request at a time: a centroid,
// threshold or query coordinate load is written as it leaves the queue, and
// a query marked last runs a search over the first n entries, where n is
// centroid_count limited to MAX_ENTRIES. The search reads one
// centroid coordinate per cycle from the centroid ram and feeds one shared
// subtract, square and accumulate pipeline, so the ram read port sets the
// rate. A result shows on the outputs for one cycle with done high and
// cannot be held off. An empty table answers without running a search.
`default_nettype none

module nearest_centroid_anomaly_classifier
    import nca_pkg::*;
#(
    parameter int MAX_ENTRIES = 128,
    parameter int DIMS        = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [KIND_BITS-1:0]          kind,
    input  wire logic [ENTRY_BITS-1:0]         entry,
    input  wire logic [DIM_BITS-1:0]           dim,
    input  wire logic signed [COORD_BITS-1:0]  coord_value,
    input  wire logic [THR_BITS-1:0]           threshold,
    input  wire logic [REGIME_BITS-1:0]        regime,
    input  wire logic                          last,
    input  wire logic                          cfg_we,
    input  wire logic [COUNT_BITS-1:0]         cfg_wdata,
    output logic                               done,
    output logic [INDEX_BITS-1:0]              best_index,
    output logic [DIST_BITS-1:0]               distance_sq,
    output logic                               anomaly,
    output logic [DEC_BITS-1:0]                decision
);

    logic [COUNT_BITS-1:0] count_reg;
    logic                  req_valid;
    logic                  pop;
    nca_req_t              req;
    nca_front_stat_t       fstat;
    nca_back_stat_t        bstat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    nca_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .DIMS        (DIMS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .kind        (kind),
        .entry       (entry),
        .dim         (dim),
        .coord_value (coord_value),
        .threshold   (threshold),
        .regime      (regime),
        .last        (last),
        .pop         (pop),
        .busy        (busy),
        .req_valid   (req_valid),
        .req         (req),
        .stat        (fstat)
    );

    nca_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .DIMS        (DIMS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .centroid_count (count_reg),
        .req_valid      (req_valid),
        .req            (req),
        .pop            (pop),
        .done           (done),
        .best_index     (best_index),
        .distance_sq    (distance_sq),
        .anomaly        (anomaly),
        .decision       (decision),
        .stat           (bstat)
    );

`ifndef SYNTH
    // cancel decision goes with the anomaly flag and only with it
    a_dec_matches_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (anomaly == (decision == DEC_CANCEL)))
        else $error("decision does not match anomaly flag");

    // a search request is queued before the back end can see it
    a_search_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_QUERY && last) |=> (fstat.fill != 2'd0))
        else $error("search request lost at the queue");

    // a result only leaves once the search engine is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !bstat.active)
        else $error("result while search still running");

    // a search only starts from a queued request
    a_start_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(bstat.active) |-> ($past(fstat.fill) != 2'd0))
        else $error("search started with empty queue");
`endif

endmodule

`default_nettype wire

[test/tb_nearest_centroid_anomaly_classifier.sv]
// self-checking testbench for the nearest centroid anomaly classifier
module tb_nearest_centroid_anomaly_classifier;
    import nca_pkg::*;

    localparam int MAX_ENTRIES   = 128;
    localparam int DIMS          = 5;
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_CYCLES  = 2_000_000;

    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

    localparam longint COORD_SPAN = (longint'(1) << COORD_BITS) - 1;
    localparam longint EMPTY_DIST = DIMS * COORD_SPAN * COORD_SPAN;

    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic [DIST_BITS-1:0]  dist_sq;
        logic                  anomalous;
        logic [DEC_BITS-1:0]   decided;
    } verdict_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic [KIND_BITS-1:0]          kind = '0;
    logic [ENTRY_BITS-1:0]         entry = '0;
    logic [DIM_BITS-1:0]           dim = '0;
    logic signed [COORD_BITS-1:0]  coord_value = '0;
    logic [THR_BITS-1:0]           threshold = '0;
    logic [REGIME_BITS-1:0]        regime = '0;
    logic                          last = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [COUNT_BITS-1:0]         cfg_wdata = '0;
    logic                          busy;
    logic                          done;
    logic [INDEX_BITS-1:0]         best_index;
    logic [DIST_BITS-1:0]          distance_sq;
    logic                          anomaly;
    logic [DEC_BITS-1:0]           decision;

    // shadow copy of the classifier state
    logic signed [COORD_BITS-1:0]  centroid_shadow [MAX_ENTRIES*DIMS];
    logic [THR_BITS-1:0]           thresh_shadow [MAX_ENTRIES];
    logic [REGIME_BITS-1:0]        regime_shadow [MAX_ENTRIES];
    logic signed [COORD_BITS-1:0]  query_shadow [DIMS];
    int                            count_shadow = 0;
    bit                            coord_loaded [MAX_ENTRIES*DIMS];
    bit                            thr_loaded [MAX_ENTRIES];
    bit                            query_loaded [DIMS];

    verdict_t verdict_queue [$];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    int       burst_left = 5;

    nearest_centroid_anomaly_classifier uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .entry       (entry),
        .dim         (dim),
        .coord_value (coord_value),
        .threshold   (threshold),
        .regime      (regime),
        .last        (last),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .best_index  (best_index),
        .distance_sq (distance_sq),
        .anomaly     (anomaly),
        .decision    (decision)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, verdict_queue.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic verdict_t nearest_verdict();
        verdict_t v;
        int       n;
        int       k;
        int       d;
        int       best;
        longint   best_sq;
        longint   sum;
        longint   diff;
        longint   thr;
        n = (count_shadow > MAX_ENTRIES) ? MAX_ENTRIES : count_shadow;
        v.index     = '0;
        v.dist_sq   = DIST_BITS'(EMPTY_DIST);
        v.anomalous = 1'b1;
        v.decided   = DEC_CANCEL;
        if (n == 0)
            return v;
        best    = 0;
        best_sq = 0;
        for (k = 0; k < n; k++)
        begin
            sum = 0;
            for (d = 0; d < DIMS; d++)
            begin
                diff = longint'(centroid_shadow[k*DIMS+d]) - longint'(query_shadow[d]);
                sum += diff * diff;
            end
            // strict compare keeps the lowest index on a tie
            if (k == 0 || sum < best_sq)
            begin
                best_sq = sum;
                best    = k;
            end
        end
        thr = longint'(thresh_shadow[best]);
        v.index     = INDEX_BITS'(best);
        v.dist_sq   = DIST_BITS'(best_sq);
        v.anomalous = (best_sq > thr * thr);
        if (v.anomalous)
            v.decided = DEC_CANCEL;
        else if (regime_shadow[best] == REGIME_TAKER)
            v.decided = DEC_TAKER;
        else if (regime_shadow[best] == REGIME_PROVISION)
            v.decided = DEC_PROVISION;
        else
            v.decided = DEC_HOLD;
        return v;
    endfunction

    function automatic bit entry_loaded(input int e);
        int d;
        for (d = 0; d < DIMS; d++)
            if (!coord_loaded[e*DIMS+d])
                return 1'b0;
        return thr_loaded[e];
    endfunction

    task automatic record_request(
        input logic [KIND_BITS-1:0]         k,
        input logic [ENTRY_BITS-1:0]        e,
        input logic [DIM_BITS-1:0]          d,
        input logic signed [COORD_BITS-1:0] c,
        input logic [THR_BITS-1:0]          t,
        input logic [REGIME_BITS-1:0]       r,
        input logic                         l
    );
        case (k)
            KIND_CENTROID:
                if (d < DIMS)
                begin
                    centroid_shadow[int'(e)*DIMS+int'(d)] = c;
                    coord_loaded[int'(e)*DIMS+int'(d)]    = 1'b1;
                end
            KIND_THRESH:
            begin
                thresh_shadow[e] = t;
                regime_shadow[e] = r;
                thr_loaded[e]    = 1'b1;
            end
            KIND_QUERY:
            begin
                if (d < DIMS)
                begin
                    query_shadow[d] = c;
                    query_loaded[d] = 1'b1;
                end
                if (l)
                    verdict_queue.insert(verdict_queue.size(), nearest_verdict());
            end
            default: ;
        endcase
    endtask

    // one request; start stays high across a burst and drops for the gaps
    task automatic issue_request(
        input logic [KIND_BITS-1:0]         k,
        input logic [ENTRY_BITS-1:0]        e,
        input logic [DIM_BITS-1:0]          d,
        input logic signed [COORD_BITS-1:0] c,
        input logic [THR_BITS-1:0]          t,
        input logic [REGIME_BITS-1:0]       r,
        input logic                         l
    );
        int gap;
        start       <= 1'b1;
        kind        <= k;
        entry       <= e;
        dim         <= d;
        coord_value <= c;
        threshold   <= t;
        regime      <= r;
        last        <= l;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        record_request(k, e, d, c, t, r, l);
        burst_left--;
        if (burst_left <= 0)
        begin
            start <= 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
                6, 7, 8:          gap = $urandom_range(4, 20);
                default:          gap = $urandom_range(30, 120);
            endcase
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic settle_idle();
        start <= 1'b0;
        while (verdict_queue.size() != 0)
            @(posedge clk);
        // queued loads may still be draining after the last result
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input int value);
        settle_idle();
        cfg_wdata <= COUNT_BITS'(value);
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        count_shadow = value;
    endtask

    function automatic logic signed [COORD_BITS-1:0] pick_coord(input int mode);
        case (mode)
            0:
                case ($urandom_range(0, 9))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    default: return COORD_BITS'($urandom());
                endcase
            // coarse grid, so ties and exact matches show up
            1:       return COORD_BITS'($urandom_range(0, 4) * 256 - 512);
            default: return COORD_BITS'($urandom_range(0, 4095) - 2048);
        endcase
    endfunction

    function automatic logic [THR_BITS-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return THR_BITS'($urandom());
            default: return THR_BITS'($urandom_range(0, 3000));
        endcase
    endfunction

    function automatic logic signed [COORD_BITS-1:0] query_coord(
        input int d,
        input int near_entry,
        input int mode
    );
        if (near_entry < 0)
            return pick_coord(mode);
        return centroid_shadow[near_entry*DIMS+d] + COORD_BITS'($urandom_range(0, 32)) - 16'sd16;
    endfunction

    task automatic set_entry(
        input int                           e,
        input logic signed [COORD_BITS-1:0] c,
        input logic [THR_BITS-1:0]          t,
        input logic [REGIME_BITS-1:0]       r
    );
        int d;
        for (d = 0; d < DIMS; d++)
            issue_request(KIND_CENTROID, ENTRY_BITS'(e), DIM_BITS'(d), c, '0, '0, 1'b0);
        issue_request(KIND_THRESH, ENTRY_BITS'(e), '0, '0, t, r, 1'b0);
    endtask

    task automatic query_all(input logic signed [COORD_BITS-1:0] c);
        int d;
        for (d = 0; d < DIMS; d++)
            issue_request(KIND_QUERY, '0, DIM_BITS'(d), c, '0, '0, d == DIMS - 1);
    endtask

    // all six pieces of one entry in a rotated order
    task automatic load_entry(input int e, input int mode);
        int offset;
        int i;
        int piece;
        offset = $urandom_range(0, DIMS);
        for (i = 0; i <= DIMS; i++)
        begin
            piece = (offset + i) % (DIMS + 1);
            if (piece < DIMS)
                issue_request(KIND_CENTROID, ENTRY_BITS'(e), DIM_BITS'(piece), pick_coord(mode),
                              THR_BITS'($urandom()), REGIME_BITS'($urandom()), 1'($urandom()));
            else
                issue_request(KIND_THRESH, ENTRY_BITS'(e), DIM_BITS'($urandom()),
                              COORD_BITS'($urandom()), pick_threshold(),
                              REGIME_BITS'($urandom()), 1'($urandom()));
        end
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0:
                issue_request(KIND_UNUSED, ENTRY_BITS'($urandom()), DIM_BITS'($urandom()),
                              COORD_BITS'($urandom()), THR_BITS'($urandom()),
                              REGIME_BITS'($urandom()), 1'($urandom()));
            // out of range dim, dropped
            1:
                issue_request(KIND_CENTROID, ENTRY_BITS'($urandom()),
                              DIM_BITS'($urandom_range(DIMS, 7)), COORD_BITS'($urandom()),
                              THR_BITS'($urandom()), REGIME_BITS'($urandom()),
                              1'($urandom()));
            2:
                issue_request(KIND_QUERY, ENTRY_BITS'($urandom()), DIM_BITS'($urandom()),
                              pick_coord(0), THR_BITS'($urandom()),
                              REGIME_BITS'($urandom()), 1'b0);
            default:
                issue_request(KIND_THRESH, ENTRY_BITS'($urandom()), DIM_BITS'($urandom()),
                              COORD_BITS'($urandom()), pick_threshold(),
                              REGIME_BITS'($urandom()), 1'($urandom()));
        endcase
    endtask

    // missing query dims always go out before the one that starts the search
    task automatic run_query(input int mode, input int n);
        int dims_list [$];
        int d;
        int final_dim;
        int near_entry;
        bit broken;
        for (d = 0; d < DIMS; d++)
            if (!query_loaded[d] || $urandom_range(0, 2) == 0)
                dims_list.insert(dims_list.size(), d);
        broken     = ($urandom_range(0, 9) == 0);
        near_entry = (n > 0 && $urandom_range(0, 1) == 1) ? $urandom_range(0, n - 1) : -1;
        if (dims_list.size() == 0 || $urandom_range(0, 5) == 0)
            final_dim = $urandom_range(DIMS, 7);
        else
            final_dim = dims_list.pop_back();
        foreach (dims_list[i])
            issue_request(KIND_QUERY, ENTRY_BITS'($urandom()), DIM_BITS'(dims_list[i]),
                          query_coord(dims_list[i], near_entry, mode), THR_BITS'($urandom()),
                          REGIME_BITS'($urandom()), 1'b0);
        issue_request(KIND_QUERY, ENTRY_BITS'($urandom()), DIM_BITS'(final_dim),
                      (final_dim < DIMS) ? query_coord(final_dim, near_entry, mode)
                                         : COORD_BITS'($urandom()),
                      THR_BITS'($urandom()), REGIME_BITS'($urandom()), !broken);
    endtask

    task automatic test_empty_table();
        write_count(0);
        issue_request(KIND_UNUSED, 7'd127, 3'd7, 16'sh7fff, 16'hffff, 2'd3, 1'b1);
        // nothing is read on an empty table, so the unwritten query buffer is fine
        issue_request(KIND_QUERY, 7'd0, 3'd7, 16'sh0000, 16'h0000, 2'd0, 1'b1);
    endtask

    task automatic test_extreme_distance();
        set_entry(0, 16'sh8000, 16'hffff, REGIME_TAKER);
        write_count(1);
        query_all(16'sh7fff);
    endtask

    task automatic test_tie_and_threshold();
        set_entry(1, 16'sh0000, 16'd40960, REGIME_PROVISION);
        write_count(2);
        // halfway between entry 0 and entry 1 in every dim
        query_all(16'shc000);
        // distance to entry 1 lands exactly on its squared threshold
        issue_request(KIND_QUERY, 7'd0, 3'd0, 16'sh6000, 16'h0000, 2'd0, 1'b1);
        issue_request(KIND_THRESH, 7'd1, 3'd0, 16'sh0000, 16'd40959, REGIME_PROVISION, 1'b0);
        issue_request(KIND_QUERY, 7'd0, 3'd5, 16'sh0123, 16'h0000, 2'd0, 1'b1);
        issue_request(KIND_THRESH, 7'd1, 3'd0, 16'sh0000, 16'd40960, 2'd3, 1'b0);
        issue_request(KIND_CENTROID, 7'd1, 3'd6, 16'sh1234, 16'h0000, 2'd0, 1'b0);
        issue_request(KIND_QUERY, 7'd0, 3'd7, 16'sh4321, 16'h0000, 2'd0, 1'b1);
        issue_request(KIND_THRESH, 7'd1, 3'd0, 16'sh0000, 16'd40960, 2'd2, 1'b0);
        issue_request(KIND_QUERY, 7'd0, 3'd6, 16'sh0000, 16'h0000, 2'd0, 1'b1);
    endtask

    task automatic test_random_traffic();
        int phase_counts [12] = '{1, 4, 0, 2, 9, 16, 3, 40, 128, 255, 200, 6};
        int p;
        int e;
        int n;
        int mode;
        int queries;
        for (p = 0; p < 12; p++)
        begin
            mode = $urandom_range(0, 2);
            write_count(phase_counts[p]);
            n = (phase_counts[p] > MAX_ENTRIES) ? MAX_ENTRIES : phase_counts[p];
            for (e = 0; e < n; e++)
                if (!entry_loaded(e))
                begin
                    load_entry(e, mode);
                    if ($urandom_range(0, 7) == 0)
                        send_noise();
                end
            queries = $urandom_range(3, 6);
            repeat (queries)
            begin
                if (n > 0 && $urandom_range(0, 7) == 0)
                    load_entry($urandom_range(0, n - 1), mode);
                if ($urandom_range(0, 4) == 0)
                    send_noise();
                run_query(mode, n);
                if ($urandom_range(0, 9) == 0)
                    settle_idle();
            end
        end
    endtask

    always @(posedge clk)
    begin : check_results
        verdict_t want;
        if (rst_n && done)
        begin
            if (verdict_queue.size() == 0)
            begin
                $display("%0t: unexpected result index %0d distance %0d", $time,
                         best_index, distance_sq);
                mismatch_count++;
            end
            else
            begin
                want = verdict_queue.pop_front();
                if (best_index !== want.index)
                begin
                    $display("%0t: best_index expected %0d got %0d", $time, want.index,
                             best_index);
                    mismatch_count++;
                end
                if (distance_sq !== want.dist_sq)
                begin
                    $display("%0t: distance_sq expected %0d got %0d", $time, want.dist_sq,
                             distance_sq);
                    mismatch_count++;
                end
                if (anomaly !== want.anomalous)
                begin
                    $display("%0t: anomaly expected %0d got %0d", $time, want.anomalous,
                             anomaly);
                    mismatch_count++;
                end
                if (decision !== want.decided)
                begin
                    $display("%0t: decision expected %0d got %0d", $time, want.decided,
                             decision);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_extreme_distance();
        test_tie_and_threshold();
        test_random_traffic();
        settle_idle();
        if (verdict_queue.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, verdict_queue.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
